// ===== rtl/cbc_pkg.sv =====
// ----------------------------------------------------------------------------
// cbc_pkg
// Shared types and constants for the cartridge bank controller: bus field
// widths, command codes, register indexes and address decode constants.
// ----------------------------------------------------------------------------
`default_nettype none

package cbc_pkg;

    // Stream payload widths (tdata fields padded to whole bytes)
    localparam int S_TDATA_W = 24;  // address[15:0], write_data[23:16]
    localparam int S_TUSER_W = 2;   // command[1:0]
    localparam int M_TDATA_W = 24;  // read_data[7:0], rom_bank_sel[14:8], ram_bank_sel[17:15]

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    // Sizes
    localparam int CBC_RAM_BANKS_MAX = 8;
    localparam int RAM_BANK_BYTES    = 8192;
    localparam int RAM_OFF_W         = 13;
    localparam int ROM_BANK_W        = 7;
    localparam int RAM_BANK_W        = 3;

    // Bus commands
    typedef enum logic [1:0] {
        CMD_CTRL_WR = 2'd0,
        CMD_RAM_WR  = 2'd1,
        CMD_RAM_RD  = 2'd2
    } cmd_t;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_MAPPER_KIND    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROM_BANK_COUNT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RAM_BANK_COUNT = 2'd2;

    // Mapper rule sets
    localparam logic MAPPER_MBC1 = 1'b0;
    localparam logic MAPPER_MBC3 = 1'b1;

    // Control area regions, decoded from address[15:13]
    localparam logic [2:0] REG_RAM_ENABLE = 3'd0;  // 0x0000-0x1FFF
    localparam logic [2:0] REG_ROM_BANK   = 3'd1;  // 0x2000-0x3FFF
    localparam logic [2:0] REG_UPPER_BANK = 3'd2;  // 0x4000-0x5FFF
    localparam logic [2:0] REG_MODE       = 3'd3;  // 0x6000-0x7FFF

    localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;
    localparam logic [7:0] READ_DISABLED  = 8'hFF;

endpackage : cbc_pkg

`default_nettype wire

// ===== rtl/cartridge_bank_controller_unit.sv =====
// ----------------------------------------------------------------------------
// cartridge_bank_controller_unit
// Cartridge bank controller with MBC1 or MBC3 register rules and an
// on-chip external RAM, driven by one bus access per stream transaction.
// ----------------------------------------------------------------------------
// After reset the block sweeps the external RAM to zero, one byte per cycle
// through the single RAM write port; s_tready stays low during the sweep
// while configuration writes are taken as usual. After that it takes one bus
// access per cycle while the result output is not stalled, and returns its
// result through stage 1, where the synchronous RAM read lands, and then the
// output register. Bank registers update in the accepting cycle, so
// back-to-back accesses always see the effect of the previous one.
`default_nettype none

module cartridge_bank_controller_unit #(
    parameter int RAM_BANKS_MAX = cbc_pkg::CBC_RAM_BANKS_MAX
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,

    // Bus access input
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [cbc_pkg::S_TDATA_W-1:0]    s_tdata,   // address[15:0], write_data[23:16]
    input  wire logic [cbc_pkg::S_TUSER_W-1:0]    s_tuser,   // command[1:0]

    // Result output
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [cbc_pkg::M_TDATA_W-1:0]    m_tdata,   // read_data[7:0],
                                                             // rom_bank_sel[14:8],
                                                             // ram_bank_sel[17:15]

    // Configuration write channel
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [cbc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [cbc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import cbc_pkg::*;

    localparam int RAM_DEPTH = RAM_BANKS_MAX * RAM_BANK_BYTES;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);

    // ------------------------------------------------------------------
    // Wrap a bank number into the RAM that is built (narrow repeated
    // subtract, at most seven steps on a 3-bit value)
    // ------------------------------------------------------------------
    function automatic logic [RAM_BANK_W-1:0] wrap_bank(input logic [RAM_BANK_W-1:0] sel);
        logic [RAM_BANK_W-1:0] v;
        v = sel;
        for (int i = 0; i < 7; i++) begin
            if (int'(v) >= RAM_BANKS_MAX) begin
                v = v - RAM_BANK_W'(RAM_BANKS_MAX);
            end
        end
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    logic                  mapper_kind_reg;
    logic [7:0]            rom_bank_count_reg;
    logic [3:0]            ram_bank_count_reg;

    logic [ROM_BANK_W-1:0] rom_bank_reg, rom_bank_next;
    logic [RAM_BANK_W-1:0] ram_bank_reg, ram_bank_next;
    logic                  bank_mode_reg, bank_mode_next;
    logic                  ram_enable_reg, ram_enable_next;

    logic                  clear_busy_reg;
    logic [RAM_AW-1:0]     clear_cnt_reg;

    logic [7:0]            ram_mem [RAM_DEPTH];
    logic [7:0]            ram_rdata_reg;

    logic                  s1_valid_reg;
    logic                  s1_read_reg;
    logic                  s1_en_reg;
    logic [ROM_BANK_W-1:0] s1_rom_reg;
    logic [RAM_BANK_W-1:0] s1_ram_reg;

    logic                  out_valid_reg;
    logic [7:0]            out_rd_reg;
    logic [ROM_BANK_W-1:0] out_rom_reg;
    logic [RAM_BANK_W-1:0] out_ram_reg;

    logic                  out_free;
    logic                  s1_adv;
    logic                  in_xact;
    cmd_t                  cmd;
    logic [15:0]           addr;
    logic [7:0]            wdata;
    logic [ROM_BANK_W-1:0] rom_mask;
    logic [RAM_BANK_W-1:0] ram_mask;
    logic [RAM_BANK_W-1:0] ram_sel_cur;
    logic [RAM_OFF_W-1:0]  ram_off;
    logic [16:0]           ram_idx_wide;
    logic [RAM_AW-1:0]     ram_idx;
    logic                  ram_wr;
    logic                  ram_rd;
    logic [7:0]            s1_read_data;

    // ------------------------------------------------------------------
    // Handshake and field unpacking
    // ------------------------------------------------------------------
    assign out_free  = !out_valid_reg || m_tready;
    assign s1_adv    = s1_valid_reg && out_free;
    assign s_tready  = !clear_busy_reg && (!s1_valid_reg || out_free);
    assign in_xact   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign cmd   = cmd_t'(s_tuser);
    assign addr  = s_tdata[15:0];
    assign wdata = s_tdata[23:16];

    // ------------------------------------------------------------------
    // Bank masks and RAM address; the window base 0xA000 has zero low
    // bits, so the in-bank offset is the low address bits
    // ------------------------------------------------------------------
    assign rom_mask     = ROM_BANK_W'(rom_bank_count_reg - 8'd1);
    assign ram_mask     = RAM_BANK_W'(ram_bank_count_reg - 4'd1);
    assign ram_sel_cur  = ram_bank_reg & ram_mask;
    assign ram_off      = addr[RAM_OFF_W-1:0];
    assign ram_idx_wide = {1'b0, wrap_bank(ram_sel_cur), ram_off};
    assign ram_idx      = ram_idx_wide[RAM_AW-1:0];

    assign ram_wr = in_xact && (cmd == CMD_RAM_WR) && ram_enable_reg;
    assign ram_rd = in_xact && (cmd == CMD_RAM_RD);

    // ------------------------------------------------------------------
    // Next bank state for a control write
    // ------------------------------------------------------------------
    always_comb begin
        rom_bank_next   = rom_bank_reg;
        ram_bank_next   = ram_bank_reg;
        bank_mode_next  = bank_mode_reg;
        ram_enable_next = ram_enable_reg;
        if (in_xact && (cmd == CMD_CTRL_WR) && !addr[15]) begin
            if (addr[14:13] == REG_RAM_ENABLE[1:0]) begin
                ram_enable_next = (wdata[3:0] == RAM_ENABLE_KEY);
            end else if (mapper_kind_reg == MAPPER_MBC3) begin
                if (addr[14:13] == REG_ROM_BANK[1:0]) begin
                    rom_bank_next = (wdata[6:0] == 7'd0) ? 7'd1 : wdata[6:0];
                end else if (addr[14:13] == REG_UPPER_BANK[1:0]) begin
                    ram_bank_next = wdata[2:0];
                end
            end else begin
                unique case (addr[14:13])
                    REG_ROM_BANK[1:0]: begin
                        rom_bank_next = {rom_bank_reg[6:5],
                                         (wdata[4:0] == 5'd0) ? 5'd1 : wdata[4:0]};
                    end
                    REG_UPPER_BANK[1:0]: begin
                        if (bank_mode_reg) begin
                            ram_bank_next = {1'b0, wdata[1:0]};
                        end else begin
                            rom_bank_next = {wdata[1:0], rom_bank_reg[4:0]};
                        end
                    end
                    REG_MODE[1:0]: begin
                        bank_mode_next = wdata[0];
                        if (wdata[0]) begin
                            rom_bank_next = {2'b00, rom_bank_reg[4:0]};
                        end else begin
                            ram_bank_next = '0;
                        end
                    end
                    default: begin
                        // enable region handled above
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Configuration and bank registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mapper_kind_reg    <= MAPPER_MBC1;
            rom_bank_count_reg <= 8'd2;
            ram_bank_count_reg <= 4'd1;
            rom_bank_reg       <= 7'd1;
            ram_bank_reg       <= '0;
            bank_mode_reg      <= 1'b0;
            ram_enable_reg     <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_MAPPER_KIND:    mapper_kind_reg    <= cfg_data[0];
                    CFG_ROM_BANK_COUNT: rom_bank_count_reg <= cfg_data;
                    CFG_RAM_BANK_COUNT: ram_bank_count_reg <= cfg_data[3:0];
                    default: begin
                        // drop writes beyond the register list
                    end
                endcase
            end
            rom_bank_reg   <= rom_bank_next;
            ram_bank_reg   <= ram_bank_next;
            bank_mode_reg  <= bank_mode_next;
            ram_enable_reg <= ram_enable_next;
        end
    end

    // ------------------------------------------------------------------
    // Clearing sweep after reset
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_busy_reg <= 1'b1;
            clear_cnt_reg  <= '0;
        end else if (clear_busy_reg) begin
            clear_cnt_reg <= clear_cnt_reg + 1'b1;
            if (clear_cnt_reg == RAM_AW'(RAM_DEPTH - 1)) begin
                clear_busy_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // External RAM: one write port, one registered read port; the read
    // register only loads on a read transaction so it holds under stall
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (clear_busy_reg) begin
            ram_mem[clear_cnt_reg] <= 8'h00;
        end else if (ram_wr) begin
            ram_mem[ram_idx] <= wdata;
        end
        if (ram_rd) begin
            ram_rdata_reg <= ram_mem[ram_idx];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: wait for RAM read data, carry bank numbers after the access
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (in_xact) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xact) begin
            s1_read_reg <= (cmd == CMD_RAM_RD);
            s1_en_reg   <= ram_enable_reg;
            s1_rom_reg  <= rom_bank_next & rom_mask;
            s1_ram_reg  <= ram_bank_next & ram_mask;
        end
    end

    // Pick the read byte: RAM data, disabled pattern, or zero for non-reads
    always_comb begin
        if (!s1_read_reg) begin
            s1_read_data = 8'h00;
        end else if (s1_en_reg) begin
            s1_read_data = ram_rdata_reg;
        end else begin
            s1_read_data = READ_DISABLED;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            out_rd_reg  <= s1_read_data;
            out_rom_reg <= s1_rom_reg;
            out_ram_reg <= s1_ram_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_ram_reg, out_rom_reg, out_rd_reg};

endmodule : cartridge_bank_controller_unit

`default_nettype wire
